@@ design/sclt_pkg.sv @@
// ----------------------------------------------------------------------------
// sclt_pkg
// Shared types and constants of the serial command LED timer.
// ----------------------------------------------------------------------------
package sclt_pkg;

  // frame length default, number of LEDs and field widths
  localparam int unsigned FRAME_LEN  = 2;
  localparam int unsigned LED_COUNT  = 4;
  localparam int unsigned LED_IDX_W  = $clog2(LED_COUNT);
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TICK_W     = 16;

  // reset value of the ticks per second register
  localparam logic [TICK_W-1:0] TPS_RESET = 16'd15;

  // command codes: lower case toggles and loads, upper case only toggles
  localparam logic [BYTE_W-1:0] CMD_LOAD_FIRST   = 8'h61;  // 'a'
  localparam logic [BYTE_W-1:0] CMD_LOAD_LAST    = 8'h64;  // 'd'
  localparam logic [BYTE_W-1:0] CMD_TOGGLE_FIRST = 8'h41;  // 'A'
  localparam logic [BYTE_W-1:0] CMD_TOGGLE_LAST  = 8'h44;  // 'D'

  // operation codes of an input request
  typedef enum logic {
    OP_RX_BYTE = 1'b0,
    OP_TICK    = 1'b1
  } op_e;

  typedef logic [LED_COUNT-1:0] led_vec_t;

  // input request payload
  typedef struct packed {
    op_e               operation;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  // result payload
  typedef struct packed {
    led_vec_t led_state;
    logic     frame_done;
    logic     second_elapsed;
  } result_t;

  // decoded command of a completed frame
  typedef struct packed {
    logic                 done;
    led_vec_t             toggle;
    logic                 load;
    logic [LED_IDX_W-1:0] idx;
    logic [BYTE_W-1:0]    duration;
  } frame_cmd_t;

endpackage

@@ design/sclt_stream_if.sv @@
// ----------------------------------------------------------------------------
// sclt_stream_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface sclt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ design/sclt_frame.sv @@
// ----------------------------------------------------------------------------
// sclt_frame
// Command frame assembly and decode of the completed frame.
// ----------------------------------------------------------------------------
module sclt_frame #(
  parameter int unsigned FrameLen = sclt_pkg::FRAME_LEN
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     byte_en_i,
  input  logic [7:0]               rx_byte_i,
  output sclt_pkg::frame_cmd_t     cmd_o
);
  import sclt_pkg::*;

  localparam int unsigned PosW = $clog2(FrameLen + 1);
  localparam logic [PosW-1:0] LastPos = PosW'(FrameLen - 1);
  localparam logic [PosW-1:0] CmdPos  = PosW'(0);
  localparam logic [PosW-1:0] DurPos  = PosW'(1);

  logic [PosW-1:0]   pos_q, pos_d;
  logic [BYTE_W-1:0] command_q, command_d;
  logic [BYTE_W-1:0] duration_q, duration_d;
  logic [BYTE_W-1:0] cmd_byte;
  logic [BYTE_W-1:0] dur_byte;
  logic              is_last;

  // frame position and byte capture
  always_comb begin
    pos_d      = pos_q;
    command_d  = command_q;
    duration_d = duration_q;
    is_last    = (pos_q == LastPos);
    if (byte_en_i) begin
      if (pos_q == CmdPos) begin
        command_d = rx_byte_i;
      end
      if (pos_q == DurPos) begin
        duration_d = rx_byte_i;
      end
      pos_d = is_last ? '0 : pos_q + PosW'(1);
    end
  end

  // command and duration as they stand once this byte is stored
  assign cmd_byte = command_d;
  assign dur_byte = duration_d;

  // decode the command of a completing frame
  always_comb begin
    cmd_o          = '0;
    cmd_o.done     = byte_en_i && is_last;
    cmd_o.duration = dur_byte;
    if (cmd_byte inside {[CMD_LOAD_FIRST:CMD_LOAD_LAST]}) begin
      cmd_o.idx  = LED_IDX_W'(cmd_byte - CMD_LOAD_FIRST);
      cmd_o.load = cmd_o.done;
    end else if (cmd_byte inside {[CMD_TOGGLE_FIRST:CMD_TOGGLE_LAST]}) begin
      cmd_o.idx  = LED_IDX_W'(cmd_byte - CMD_TOGGLE_FIRST);
    end
    if (cmd_o.done && (cmd_byte inside {[CMD_LOAD_FIRST:CMD_LOAD_LAST],
                                        [CMD_TOGGLE_FIRST:CMD_TOGGLE_LAST]})) begin
      cmd_o.toggle = led_vec_t'(1) << cmd_o.idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      command_q  <= '0;
      duration_q <= '0;
    end else begin
      pos_q      <= pos_d;
      command_q  <= command_d;
      duration_q <= duration_d;
    end
  end

endmodule

@@ design/sclt_tick.sv @@
// ----------------------------------------------------------------------------
// sclt_tick
// Timer tick counter and ticks per second register.
// ----------------------------------------------------------------------------
module sclt_tick (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tick_en_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  output logic        second_o
);
  import sclt_pkg::*;

  logic [TICK_W-1:0] tps_q;
  logic [TICK_W-1:0] count_q, count_d;
  logic [TICK_W-1:0] count_inc;

  // count ticks, a match with the register ends the second
  always_comb begin
    count_inc = count_q + TICK_W'(1);
    second_o  = tick_en_i && (count_inc == tps_q);
    count_d   = count_q;
    if (tick_en_i) begin
      count_d = second_o ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      tps_q   <= TPS_RESET;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        tps_q <= cfg_data_i;
      end
    end
  end

endmodule

@@ design/sclt_leds.sv @@
// ----------------------------------------------------------------------------
// sclt_leds
// LED levels and per-LED countdowns.
// ----------------------------------------------------------------------------
module sclt_leds (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sclt_pkg::frame_cmd_t cmd_i,
  input  logic                 second_i,
  output sclt_pkg::led_vec_t   leds_d_o
);
  import sclt_pkg::*;

  led_vec_t          leds_q, leds_d;
  logic [BYTE_W-1:0] cd_q [LED_COUNT];
  logic [BYTE_W-1:0] cd_d [LED_COUNT];

  // toggle and load on a command, decrement all on a second
  always_comb begin
    leds_d = leds_q ^ cmd_i.toggle;
    for (int i = 0; i < LED_COUNT; i++) begin
      cd_d[i] = cd_q[i];
      if (cmd_i.load && (cmd_i.idx == LED_IDX_W'(i))) begin
        cd_d[i] = cmd_i.duration;
      end
      if (second_i) begin
        cd_d[i] = cd_q[i] - BYTE_W'(1);
        if (cd_d[i] == '0) begin
          leds_d[i] = 1'b0;
        end
      end
    end
  end

  assign leds_d_o = leds_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leds_q <= '0;
      for (int i = 0; i < LED_COUNT; i++) begin
        cd_q[i] <= '0;
      end
    end else begin
      leds_q <= leds_d;
      for (int i = 0; i < LED_COUNT; i++) begin
        cd_q[i] <= cd_d[i];
      end
    end
  end

endmodule

@@ design/serial_command_led_timer.sv @@
// Path: a request passes the input register, then the result register; a
// stalled result holds it in the input register.
// Throughput: one request per cycle while results drain, set by the single
// pass of frame decode, tick compare and countdown update between the two
// registers.
// Reset: all but data registers clear at once, ticks per second back to 15.
// ----------------------------------------------------------------------------
// serial_command_led_timer
// Four-LED controller driven by serial command frames and timer ticks.
// ----------------------------------------------------------------------------
module serial_command_led_timer #(
  parameter int unsigned FrameLen = sclt_pkg::FRAME_LEN
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sclt_stream_if.sink   item_i,
  sclt_stream_if.source result_o,
  sclt_stream_if.sink   cfg_i
);
  import sclt_pkg::*;

  logic       in_valid_q;
  item_t      in_q;
  logic       out_valid_q;
  result_t    out_q;
  logic       advance;
  frame_cmd_t frame_cmd;
  logic       second;
  led_vec_t   leds_d;
  item_t      item_in;

  assign item_in = item_t'(item_i.payload);

  // the pass runs when the result register is free or being drained
  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || advance;
  assign cfg_i.ready  = 1'b1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      in_q <= item_in;
    end
  end

  sclt_frame #(
    .FrameLen (FrameLen)
  ) u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (advance && (in_q.operation == OP_RX_BYTE)),
    .rx_byte_i (in_q.rx_byte),
    .cmd_o     (frame_cmd)
  );

  sclt_tick u_tick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_en_i  (advance && (in_q.operation == OP_TICK)),
    .cfg_we_i   (cfg_i.valid && cfg_i.ready),
    .cfg_data_i (cfg_i.payload),
    .second_o   (second)
  );

  sclt_leds u_leds (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (frame_cmd),
    .second_i (second),
    .leds_d_o (leds_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.led_state      <= leds_d;
      out_q.frame_done     <= frame_cmd.done;
      out_q.second_elapsed <= second;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

  // a result never reports both a frame and a second
  a_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.frame_done && out_q.second_elapsed))
    else $error("frame_done and second_elapsed both set");

  // every pass lands in the result register
  a_pass_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("pass did not produce a result");

  // a serial byte never ends a second, a tick never ends a frame
  a_op_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> ((in_q.operation == OP_RX_BYTE) ? !second : !frame_cmd.done))
    else $error("result flag does not match request kind");

  // a stalled result keeps its LED state
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed");

endmodule

@@ verif/serial_command_led_timer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_led_timer_tb
// Self-checking bench for the serial command LED timer. A behavioral model
// of the frame decoder, tick counter and countdowns predicts the result of
// every accepted request. Stimulus is a short directed table followed by
// random command frames, noise bytes and ticks under several ticks per second
// settings, with random idling on both channels and one long receiver hold.
// ----------------------------------------------------------------------------
module serial_command_led_timer_tb;
  import sclt_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned HOLD_CYCLES    = 400;

  // one request with an optional hand-written result
  typedef struct packed {
    item_t   req;
    logic    known;
    result_t want;
  } stim_t;

  logic clk_i;
  logic rst_ni;

  sclt_stream_if #(.payload_t(item_t))             item_ch ();
  sclt_stream_if #(.payload_t(result_t))           result_ch ();
  sclt_stream_if #(.payload_t(logic [TICK_W-1:0])) cfg_ch ();

  serial_command_led_timer dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  // requests waiting to be sent and results waiting to arrive
  stim_t   stim_q[$];
  result_t led_result_q[$];

  int unsigned err_count    = 0;
  int unsigned send_gap     = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_en      = 1'b1;

  // behavioral copy of the block state
  logic [TICK_W-1:0] tps_reg   = TPS_RESET;
  logic [3:0]        frame_pos = '0;
  logic [BYTE_W-1:0] frame_cmd = '0;
  logic [BYTE_W-1:0] frame_dur = '0;
  logic [TICK_W-1:0] tick_cnt  = '0;
  logic [BYTE_W-1:0] countdown [LED_COUNT] = '{default: '0};
  led_vec_t          led_lvl   = '0;

  // directed requests, starting from reset with 15 ticks per second
  stim_t directed_tbl [23] = '{
    '{'{OP_TICK,    8'hFF}, 1'b1, '{4'h0, 1'b0, 1'b0}},  // tick, byte ignored
    '{'{OP_RX_BYTE, 8'h61}, 1'b1, '{4'h0, 1'b0, 1'b0}},  // 'a'
    '{'{OP_RX_BYTE, 8'h03}, 1'b1, '{4'h1, 1'b1, 1'b0}},  // load led 0
    '{'{OP_RX_BYTE, 8'h42}, 1'b1, '{4'h1, 1'b0, 1'b0}},  // 'B'
    '{'{OP_RX_BYTE, 8'hFF}, 1'b1, '{4'h3, 1'b1, 1'b0}},  // toggle only
    '{'{OP_RX_BYTE, 8'h64}, 1'b1, '{4'h3, 1'b0, 1'b0}},  // 'd'
    '{'{OP_RX_BYTE, 8'h00}, 1'b1, '{4'hB, 1'b1, 1'b0}},  // load zero
    '{'{OP_RX_BYTE, 8'h44}, 1'b1, '{4'hB, 1'b0, 1'b0}},  // 'D'
    '{'{OP_RX_BYTE, 8'h80}, 1'b1, '{4'h3, 1'b1, 1'b0}},
    '{'{OP_RX_BYTE, 8'h63}, 1'b0, '{4'h0, 1'b0, 1'b0}},  // 'c'
    '{'{OP_RX_BYTE, 8'h01}, 1'b1, '{4'h7, 1'b1, 1'b0}},
    '{'{OP_RX_BYTE, 8'h65}, 1'b1, '{4'h7, 1'b0, 1'b0}},  // 'e' just past loads
    '{'{OP_RX_BYTE, 8'h02}, 1'b1, '{4'h7, 1'b1, 1'b0}},
    '{'{OP_RX_BYTE, 8'h60}, 1'b1, '{4'h7, 1'b0, 1'b0}},  // just below loads
    '{'{OP_RX_BYTE, 8'h55}, 1'b1, '{4'h7, 1'b1, 1'b0}},
    '{'{OP_RX_BYTE, 8'h45}, 1'b1, '{4'h7, 1'b0, 1'b0}},  // 'E' just past toggles
    '{'{OP_RX_BYTE, 8'h00}, 1'b1, '{4'h7, 1'b1, 1'b0}},
    '{'{OP_RX_BYTE, 8'h40}, 1'b1, '{4'h7, 1'b0, 1'b0}},  // just below toggles
    '{'{OP_RX_BYTE, 8'hAA}, 1'b1, '{4'h7, 1'b1, 1'b0}},
    '{'{OP_RX_BYTE, 8'h41}, 1'b1, '{4'h7, 1'b0, 1'b0}},  // 'A'
    '{'{OP_TICK,    8'h00}, 1'b1, '{4'h7, 1'b0, 1'b0}},  // tick inside a frame
    '{'{OP_RX_BYTE, 8'h7F}, 1'b1, '{4'h6, 1'b1, 1'b0}},
    '{'{OP_RX_BYTE, 8'hFF}, 1'b0, '{4'h0, 1'b0, 1'b0}}   // leaves a frame open
  };

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // advance the behavioral state by one request and return its result
  function automatic result_t led_timer_step(item_t req);
    result_t              res;
    logic [3:0]           nxt_pos;
    logic [TICK_W-1:0]    nxt_tick;
    logic [LED_IDX_W-1:0] idx;
    int                   i;
    res = '0;
    if (req.operation == OP_RX_BYTE) begin
      if (frame_pos == 4'd0) frame_cmd = req.rx_byte;
      else if (frame_pos == 4'd1) frame_dur = req.rx_byte;
      nxt_pos = frame_pos + 4'd1;
      if (nxt_pos == 4'(FRAME_LEN)) begin
        frame_pos = '0;
        res.frame_done = 1'b1;
        if (frame_cmd >= CMD_LOAD_FIRST && frame_cmd <= CMD_LOAD_LAST) begin
          idx = LED_IDX_W'(frame_cmd - CMD_LOAD_FIRST);
          led_lvl[idx] = ~led_lvl[idx];
          countdown[idx] = frame_dur;
        end else if (frame_cmd >= CMD_TOGGLE_FIRST && frame_cmd <= CMD_TOGGLE_LAST) begin
          idx = LED_IDX_W'(frame_cmd - CMD_TOGGLE_FIRST);
          led_lvl[idx] = ~led_lvl[idx];
        end
      end else begin
        frame_pos = nxt_pos;
      end
    end else begin
      nxt_tick = tick_cnt + 1'b1;
      if (nxt_tick == tps_reg) begin
        tick_cnt = '0;
        res.second_elapsed = 1'b1;
        // every countdown wraps down; reaching zero forces the led off
        for (i = 0; i < LED_COUNT; i++) begin
          countdown[i] = countdown[i] - 1'b1;
          if (countdown[i] == '0) led_lvl[i] = 1'b0;
        end
      end else begin
        tick_cnt = nxt_tick;
      end
    end
    res.led_state = led_lvl;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  function automatic void push_req(op_e op, logic [BYTE_W-1:0] b);
    stim_t s;
    s = '0;
    s.req.operation = op;
    s.req.rx_byte = b;
    stim_q.push_back(s);
  endfunction

  // random ticks, noise bytes and command frames with random content
  function automatic void add_traffic(int n, int tick_pct);
    int                r;
    int                k;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] dur;
    k = 0;
    while (k < n) begin
      r = $urandom_range(0, 99);
      if (r < tick_pct) begin
        push_req(OP_TICK, BYTE_W'($urandom_range(0, 255)));
        k++;
      end else if (r < tick_pct + 8) begin
        push_req(OP_RX_BYTE, BYTE_W'($urandom_range(0, 255)));
        k++;
      end else begin
        r = $urandom_range(0, 9);
        if (r < 4) cmd = CMD_LOAD_FIRST + BYTE_W'($urandom_range(0, 3));
        else if (r < 8) cmd = CMD_TOGGLE_FIRST + BYTE_W'($urandom_range(0, 3));
        else cmd = BYTE_W'($urandom_range(0, 255));
        // mostly short durations so countdowns run out
        if ($urandom_range(0, 3) == 0) dur = BYTE_W'($urandom_range(0, 255));
        else dur = BYTE_W'($urandom_range(0, 5));
        push_req(OP_RX_BYTE, cmd);
        k += 2;
        if ($urandom_range(0, 6) == 0) begin
          push_req(OP_TICK, BYTE_W'($urandom_range(0, 255)));
          k++;
        end
        push_req(OP_RX_BYTE, dur);
      end
    end
  endfunction

  // wait until every request is sent and every result has come back
  task automatic wait_drained();
    do @(posedge clk_i);
    while (stim_q.size() != 0 || item_ch.valid || led_result_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tps(logic [TICK_W-1:0] value);
    @(posedge clk_i);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= value;
    do @(posedge clk_i);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    tps_reg = value;
  endtask

  task automatic run_phase(int n, int tick_pct, bit idle, int unsigned hold);
    @(negedge clk_i);
    idle_en   = idle;
    hold_left = hold;
    add_traffic(n, tick_pct);
    wait_drained();
  endtask

  // request sender: predicts on acceptance, then offers the next request
  always @(posedge clk_i) begin : request_sender
    stim_t   cur;
    result_t predicted;
    if (rst_ni) begin
      if (item_ch.valid && item_ch.ready) begin
        predicted = led_timer_step(item_ch.payload);
        cur = stim_q.pop_front();
        led_result_q.push_back(cur.known ? cur.want : predicted);
        if (idle_en && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 16);
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (send_gap > 0) begin
          item_ch.valid <= 1'b0;
          send_gap--;
        end else if (stim_q.size() != 0) begin
          item_ch.valid   <= 1'b1;
          item_ch.payload <= stim_q[0].req;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: checks against the oldest expectation, stalls at random
  always @(posedge clk_i) begin : result_receiver
    result_t want;
    if (rst_ni) begin
      if (result_ch.valid && result_ch.ready) begin
        if (led_result_q.size() == 0) begin
          report_mismatch("result with none due, led_state",
                          int'(result_ch.payload.led_state), 0);
        end else begin
          want = led_result_q.pop_front();
          if (result_ch.payload.led_state !== want.led_state)
            report_mismatch("led_state", int'(result_ch.payload.led_state),
                            int'(want.led_state));
          if (result_ch.payload.frame_done !== want.frame_done)
            report_mismatch("frame_done", int'(result_ch.payload.frame_done),
                            int'(want.frame_done));
          if (result_ch.payload.second_elapsed !== want.second_elapsed)
            report_mismatch("second_elapsed", int'(result_ch.payload.second_elapsed),
                            int'(want.second_elapsed));
        end
      end
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        result_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 15);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no request moving on any channel
  always @(posedge clk_i) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence
  initial begin : main_seq
    int k;
    rst_ni          = 1'b0;
    item_ch.valid   = 1'b0;
    item_ch.payload = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.payload  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table at the reset tick rate
    for (k = 0; k < $size(directed_tbl); k++) stim_q.push_back(directed_tbl[k]);
    wait_drained();

    run_phase(200, 20, 1'b1, 0);
    write_tps(16'd1);
    run_phase(250, 25, 1'b1, 0);
    write_tps(16'd3);
    run_phase(250, 25, 1'b1, 0);

    // long receiver hold while the sender keeps offering
    write_tps(16'd2);
    run_phase(300, 30, 1'b0, HOLD_CYCLES);

    write_tps(16'd7);
    run_phase(250, 20, 1'b1, 0);

    // another stretch with no idling
    write_tps(16'd4);
    run_phase(250, 25, 1'b0, 0);

    write_tps(16'hFFFF);
    run_phase(100, 30, 1'b0, 0);

    // lower the register below the count, the count runs on past it
    run_phase(40, 100, 1'b0, 0);
    write_tps(16'd5);
    run_phase(40, 100, 1'b0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ serial_command_led_timer.f @@
design/sclt_pkg.sv
design/sclt_stream_if.sv
design/sclt_frame.sv
design/sclt_tick.sv
design/sclt_leds.sv
design/serial_command_led_timer.sv
verif/serial_command_led_timer_tb.sv
